// ===== rtl/soft_sphere_pair_force_unit_defines.svh =====
// Assertion macros shared by the checker
`ifndef SOFT_SPHERE_PAIR_FORCE_UNIT_DEFINES_SVH
`define SOFT_SPHERE_PAIR_FORCE_UNIT_DEFINES_SVH

// same-cycle implication, masked during reset
`define SSP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pair force check failed");

// next-cycle implication, masked during reset
`define SSP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pair force check failed");

`endif

// ===== rtl/ssp_pkg.sv =====
package ssp_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int LEN_W       = 11;
	localparam int POS_IN_W    = 26;
	localparam int RAD_W       = 18;
	localparam int RS_W        = RAD_W + 1;
	localparam int ID_W        = 10;
	localparam int SHEAR_W     = 27;
	localparam int STIFF_W     = 21;
	localparam int OUT_W       = 32;
	localparam int ENERGY_W    = 19;

	// internal position and separation widths
	localparam int POS_W       = 30;
	localparam int MAG_W       = POS_W - 1;
	localparam int SQ_W        = 2 * MAG_W;
	localparam int D2_W        = SQ_W + 2;
	localparam int DIFF_W      = RS_W + 1;
	localparam int CD2_W       = 2 * RS_W;
	localparam int ROOT_W      = RS_W;
	localparam int SQ_N        = ROOT_W;
	localparam int FPROD_W     = STIFF_W + RS_W;
	localparam int F_W         = FPROD_W - FRAC_BITS;
	localparam int ESQ_W       = 2 * RS_W;
	localparam int NUM_W       = F_W + RS_W;
	localparam int QUO_W       = F_W;
	localparam int DIV_N       = QUO_W;
	localparam int FRC_W       = QUO_W + 1;
	localparam int MOM_W       = FRC_W + DIFF_W + 1;
	localparam int AXES        = 3;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 27;

	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = 2;

	localparam logic [LEN_W-1:0]    LEN_RST     = 11'd10;
	localparam logic [STIFF_W-1:0]  STIFF_RST   = 21'd65536;
	localparam logic [ENERGY_W-1:0] ENERGY_MAX  = '1;

	// floor(n/3) = (n * 43691) >> 17 for n below 2^16
	localparam int THIRD_RECIP = 43691;
	localparam int THIRD_SHIFT = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_X   = 3'd0,
		REG_BOX_Y   = 3'd1,
		REG_BOX_Z   = 3'd2,
		REG_SHEAR   = 3'd3,
		REG_STIFF   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [LEN_W-1:0]          len_x;
		logic [LEN_W-1:0]          len_y;
		logic [LEN_W-1:0]          len_z;
		logic [LEN_W-1:0]          thr_x;
		logic [LEN_W-1:0]          thr_y;
		logic [LEN_W-1:0]          thr_z;
		logic signed [SHEAR_W-1:0] shear;
		logic [STIFF_W-1:0]        stiff;
	} cfg_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic signed [DIFF_W-1:0] dz;
		logic [CD2_W-1:0]         d2;
		logic [RS_W-1:0]          rs;
		logic                     contact;
	} pair_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_sts_t;

	function automatic logic [LEN_W-1:0] two_thirds(input logic [LEN_W-1:0] len);
		logic [LEN_W+THIRD_SHIFT-1:0] p;
		p = (LEN_W+THIRD_SHIFT)'({len, 1'b0}) * (LEN_W+THIRD_SHIFT)'(THIRD_RECIP);
		return p[THIRD_SHIFT +: LEN_W];
	endfunction

endpackage

// ===== rtl/soft_sphere_pair_force_unit.sv =====
// Throughput: one pair per cycle while neither a full queue (in_stall) nor out_stall holds the flow;
// fully pipelined through the 19-stage square root and three 24-stage dividers;
// a 4-entry queue separates the classifier from them.
// Reset (arst_n low, asynchronous): pipeline and queue emptied, boxes 10,
// shear offset 0, stiffness 1.0; configuration writes are taken every cycle.
module soft_sphere_pair_force_unit import ssp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [POS_IN_W-1:0]      self_pos_x,
	input  logic [POS_IN_W-1:0]      self_pos_y,
	input  logic [POS_IN_W-1:0]      self_pos_z,
	input  logic [POS_IN_W-1:0]      other_pos_x,
	input  logic [POS_IN_W-1:0]      other_pos_y,
	input  logic [POS_IN_W-1:0]      other_pos_z,
	input  logic [RAD_W-1:0]         self_radius,
	input  logic [RAD_W-1:0]         other_radius,
	input  logic [ID_W-1:0]          self_ident,
	input  logic [ID_W-1:0]          other_ident,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [OUT_W-1:0]  force_x,
	output logic signed [OUT_W-1:0]  force_y,
	output logic signed [OUT_W-1:0]  force_z,
	output logic signed [OUT_W-1:0]  shear_moment,
	output logic [ENERGY_W-1:0]      overlap_energy,
	output logic                     in_contact
);

	cfg_t      cfg_q;
	fifo_ctl_t fifo_ctl;
	fifo_sts_t fifo_sts;
	pair_t     fifo_wdata, fifo_rdata;

	assign cfg_ready = 1'b1;

	// the two-thirds threshold is worked out as the length is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.len_x <= LEN_RST;
			cfg_q.len_y <= LEN_RST;
			cfg_q.len_z <= LEN_RST;
			cfg_q.thr_x <= two_thirds(LEN_RST);
			cfg_q.thr_y <= two_thirds(LEN_RST);
			cfg_q.thr_z <= two_thirds(LEN_RST);
			cfg_q.shear <= '0;
			cfg_q.stiff <= STIFF_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BOX_X: begin
					cfg_q.len_x <= cfg_data[LEN_W-1:0];
					cfg_q.thr_x <= two_thirds(cfg_data[LEN_W-1:0]);
				end
				REG_BOX_Y: begin
					cfg_q.len_y <= cfg_data[LEN_W-1:0];
					cfg_q.thr_y <= two_thirds(cfg_data[LEN_W-1:0]);
				end
				REG_BOX_Z: begin
					cfg_q.len_z <= cfg_data[LEN_W-1:0];
					cfg_q.thr_z <= two_thirds(cfg_data[LEN_W-1:0]);
				end
				REG_SHEAR: begin
					cfg_q.shear <= cfg_data[SHEAR_W-1:0];
				end
				REG_STIFF: begin
					cfg_q.stiff <= cfg_data[STIFF_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	ssp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.self_pos_x   (self_pos_x),
		.self_pos_y   (self_pos_y),
		.self_pos_z   (self_pos_z),
		.other_pos_x  (other_pos_x),
		.other_pos_y  (other_pos_y),
		.other_pos_z  (other_pos_z),
		.self_radius  (self_radius),
		.other_radius (other_radius),
		.self_ident   (self_ident),
		.other_ident  (other_ident),
		.sts          (fifo_sts),
		.push         (fifo_ctl.push),
		.wdata        (fifo_wdata)
	);

	ssp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fifo_ctl),
		.sts    (fifo_sts),
		.wdata  (fifo_wdata),
		.rdata  (fifo_rdata)
	);

	ssp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.sts            (fifo_sts),
		.rdata          (fifo_rdata),
		.pop            (fifo_ctl.pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.force_x        (force_x),
		.force_y        (force_y),
		.force_z        (force_z),
		.shear_moment   (shear_moment),
		.overlap_energy (overlap_energy),
		.in_contact     (in_contact)
	);

endmodule

// ===== rtl/ssp_front.sv =====
module ssp_front import ssp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [POS_IN_W-1:0]   self_pos_x,
	input  logic [POS_IN_W-1:0]   self_pos_y,
	input  logic [POS_IN_W-1:0]   self_pos_z,
	input  logic [POS_IN_W-1:0]   other_pos_x,
	input  logic [POS_IN_W-1:0]   other_pos_y,
	input  logic [POS_IN_W-1:0]   other_pos_z,
	input  logic [RAD_W-1:0]      self_radius,
	input  logic [RAD_W-1:0]      other_radius,
	input  logic [ID_W-1:0]       self_ident,
	input  logic [ID_W-1:0]       other_ident,
	input  fifo_sts_t             sts,
	output logic                  push,
	output pair_t                 wdata
);

	logic en;

	logic signed [POS_W-1:0] sx0, sy0, sz0, ox0, oy0, oz0;
	logic signed [POS_W-1:0] ly, lz, ty, tz, sh;
	logic signed [POS_W-1:0] sx1, sy1, sz1, dyo, dzo;

	logic                    v_s1, v_s2, v_s3;
	logic signed [POS_W-1:0] sx_s1, ox_s1, dy_s1, dz_s1;
	logic [RS_W-1:0]         rs_s1, rs_s2, rs_s3;
	logic                    idne_s1, idne_s2, idne_s3;

	logic signed [POS_W-1:0] lx, tx, sx2, dxo;
	logic signed [POS_W-1:0] dx_s2, dy_s2, dz_s2;
	logic signed [POS_W-1:0] dx_s3, dy_s3, dz_s3;
	logic [SQ_W-1:0]         sqx_s3, sqy_s3, sqz_s3;
	logic [CD2_W-1:0]        rs2_s3;
	logic [D2_W-1:0]         d2;
	logic                    contact;

	function automatic logic [MAG_W-1:0] mag(input logic signed [POS_W-1:0] d);
		logic signed [POS_W-1:0] n;
		n = d[POS_W-1] ? -d : d;
		return n[MAG_W-1:0];
	endfunction

	assign en       = !sts.full;
	assign in_stall = sts.full;

	// y image first, then z; x waits for the sheared self x
	always_comb begin
		sx0 = POS_W'(self_pos_x);
		sy0 = POS_W'(self_pos_y);
		sz0 = POS_W'(self_pos_z);
		ox0 = POS_W'(other_pos_x);
		oy0 = POS_W'(other_pos_y);
		oz0 = POS_W'(other_pos_z);
		ly  = POS_W'({cfg.len_y, {FRAC_BITS{1'b0}}});
		lz  = POS_W'({cfg.len_z, {FRAC_BITS{1'b0}}});
		ty  = POS_W'({cfg.thr_y, {FRAC_BITS{1'b0}}});
		tz  = POS_W'({cfg.thr_z, {FRAC_BITS{1'b0}}});
		sh  = {{(POS_W-SHEAR_W){cfg.shear[SHEAR_W-1]}}, cfg.shear};
		dyo = oy0 - sy0;
		dzo = oz0 - sz0;
		sx1 = sx0;
		sy1 = sy0;
		if (dyo > ty) begin
			sy1 = sy0 + ly;
			sx1 = sx0 + sh;
		end else if (-dyo > ty) begin
			sy1 = sy0 - ly;
			sx1 = sx0 - sh;
		end
		sz1 = sz0;
		if (-dzo > tz) begin
			sz1 = sz0 - lz;
		end else if (dzo > tz) begin
			sz1 = sz0 + lz;
		end
	end

	always_comb begin
		lx  = POS_W'({cfg.len_x, {FRAC_BITS{1'b0}}});
		tx  = POS_W'({cfg.thr_x, {FRAC_BITS{1'b0}}});
		dxo = ox_s1 - sx_s1;
		sx2 = sx_s1;
		if (-dxo > tx) begin
			sx2 = sx_s1 - lx;
		end else if (dxo > tx) begin
			sx2 = sx_s1 + lx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1   <= sx1;
			ox_s1   <= ox0;
			dy_s1   <= sy1 - oy0;
			dz_s1   <= sz1 - oz0;
			rs_s1   <= RS_W'(self_radius) + RS_W'(other_radius);
			idne_s1 <= self_ident != other_ident;

			dx_s2   <= sx2 - ox_s1;
			dy_s2   <= dy_s1;
			dz_s2   <= dz_s1;
			rs_s2   <= rs_s1;
			idne_s2 <= idne_s1;

			sqx_s3  <= SQ_W'(mag(dx_s2)) * SQ_W'(mag(dx_s2));
			sqy_s3  <= SQ_W'(mag(dy_s2)) * SQ_W'(mag(dy_s2));
			sqz_s3  <= SQ_W'(mag(dz_s2)) * SQ_W'(mag(dz_s2));
			rs2_s3  <= CD2_W'(rs_s2) * CD2_W'(rs_s2);
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			dz_s3   <= dz_s2;
			rs_s3   <= rs_s2;
			idne_s3 <= idne_s2;
		end
	end

	// classify: a pair out of contact goes on as zeros
	always_comb begin
		d2      = D2_W'(sqx_s3) + D2_W'(sqy_s3) + D2_W'(sqz_s3);
		contact = idne_s3 && (d2 <= D2_W'(rs2_s3));
		push    = v_s3 && en;
		wdata.contact = contact;
		wdata.dx      = contact ? dx_s3[DIFF_W-1:0] : '0;
		wdata.dy      = contact ? dy_s3[DIFF_W-1:0] : '0;
		wdata.dz      = contact ? dz_s3[DIFF_W-1:0] : '0;
		wdata.d2      = contact ? d2[CD2_W-1:0] : '0;
		wdata.rs      = contact ? rs_s3 : '0;
	end

endmodule

// ===== rtl/ssp_fifo.sv =====
module ssp_fifo import ssp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  fifo_ctl_t ctl,
	output fifo_sts_t sts,
	input  pair_t     wdata,
	output pair_t     rdata
);

	pair_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign sts.full  = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign sts.empty = count_q == '0;
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (ctl.pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (ctl.push && !ctl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.pop && !ctl.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/ssp_back.sv =====
module ssp_back import ssp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  fifo_sts_t                sts,
	input  pair_t                    rdata,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [OUT_W-1:0]  force_x,
	output logic signed [OUT_W-1:0]  force_y,
	output logic signed [OUT_W-1:0]  force_z,
	output logic signed [OUT_W-1:0]  shear_moment,
	output logic [ENERGY_W-1:0]      overlap_energy,
	output logic                     in_contact
);

	typedef struct packed {
		logic [ROOT_W-1:0]        delta;
		logic [AXES-1:0]          sgn;
		logic signed [DIFF_W-1:0] dy;
		logic [ENERGY_W-1:0]      energy;
		logic                     contact;
	} div_pay_t;

	logic en;

	// square root pipeline
	logic              sq_v_s    [SQ_N+1];
	logic [CD2_W-1:0]  sq_rem_s  [SQ_N+1];
	logic [ROOT_W-1:0] sq_root_s [SQ_N+1];
	pair_t             sq_pay_s  [SQ_N+1];

	logic                     v_s1, v_s2, v_s3;
	logic [RS_W-1:0]          ovl_s1;
	logic [ROOT_W-1:0]        dlt_s1, dlt_s2, dlt_s3;
	pair_t                    pay_s1, pay_s2;
	logic [FPROD_W-1:0]       fprod_s2;
	logic [ESQ_W-1:0]         esq_s2;
	logic [F_W-1:0]           f_s3;
	logic [ENERGY_W-1:0]      energy_s3;
	logic [RS_W-1:0]          mag_s3 [AXES];
	logic [AXES-1:0]          sgn_s3;
	logic signed [DIFF_W-1:0] dy_s3;
	logic                     contact_s3;

	logic signed [DIFF_W-1:0]  d_ax [AXES];
	logic [ESQ_W-FRAC_BITS-2:0] esh;

	// divider pipeline, index 0 holds the numerators
	logic            dv_v_s   [DIV_N+1];
	logic [NUM_W-1:0] dv_rem_s [DIV_N+1][AXES];
	logic [QUO_W-1:0] dv_quo_s [DIV_N+1][AXES];
	div_pay_t         dv_pay_s [DIV_N+1];

	logic                     v_s5, v_s6;
	logic signed [FRC_W-1:0]  frc_s5 [AXES];
	logic signed [FRC_W-1:0]  frc_s6 [AXES];
	logic signed [DIFF_W-1:0] dy_s5;
	logic [ENERGY_W-1:0]      energy_s5, energy_s6;
	logic                     contact_s5, contact_s6;
	logic signed [MOM_W-1:0]  mom_s6;
	logic signed [MOM_W-1:0]  mom_a, mom_b, mom_sh;
	logic signed [DIFF_W:0]   ndy;

	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  force_x_q, force_y_q, force_z_q, moment_q;
	logic [ENERGY_W-1:0]      energy_q;
	logic                     contact_q;

	assign en  = !(out_valid_q && out_stall);
	assign pop = en && !sts.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (en) begin
			sq_v_s[0] <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rem_s[0]  <= rdata.d2;
			sq_root_s[0] <= '0;
			sq_pay_s[0]  <= rdata;
		end
	end

	// one root bit a stage, most significant first
	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		localparam int B = SQ_N - 1 - k;
		logic [CD2_W-1:0] trial;

		assign trial = (CD2_W'(sq_root_s[k]) << (B + 1)) | (CD2_W'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_pay_s[k+1] <= sq_pay_s[k];
				if (sq_rem_s[k] >= trial) begin
					sq_rem_s[k+1]  <= sq_rem_s[k] - trial;
					sq_root_s[k+1] <= sq_root_s[k] | (ROOT_W'(1) << B);
				end else begin
					sq_rem_s[k+1]  <= sq_rem_s[k];
					sq_root_s[k+1] <= sq_root_s[k];
				end
			end
		end
	end

	always_comb begin
		d_ax[0] = pay_s2.dx;
		d_ax[1] = pay_s2.dy;
		d_ax[2] = pay_s2.dz;
		esh     = esq_s2[ESQ_W-1:FRAC_BITS+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			v_s1 <= sq_v_s[SQ_N];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			dv_v_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovl_s1   <= sq_pay_s[SQ_N].rs - sq_root_s[SQ_N];
			dlt_s1   <= sq_root_s[SQ_N];
			pay_s1   <= sq_pay_s[SQ_N];

			fprod_s2 <= FPROD_W'(cfg.stiff) * FPROD_W'(ovl_s1);
			esq_s2   <= ESQ_W'(ovl_s1) * ESQ_W'(ovl_s1);
			dlt_s2   <= dlt_s1;
			pay_s2   <= pay_s1;

			f_s3       <= fprod_s2[FRAC_BITS +: F_W];
			energy_s3  <= (|esh[ESQ_W-FRAC_BITS-2:ENERGY_W]) ? ENERGY_MAX : esh[ENERGY_W-1:0];
			dlt_s3     <= dlt_s2;
			dy_s3      <= pay_s2.dy;
			contact_s3 <= pay_s2.contact;
			for (int a = 0; a < AXES; a++) begin
				sgn_s3[a] <= d_ax[a][DIFF_W-1];
				mag_s3[a] <= d_ax[a][DIFF_W-1] ? RS_W'(-d_ax[a]) : RS_W'(d_ax[a]);
			end

			for (int a = 0; a < AXES; a++) begin
				dv_rem_s[0][a] <= NUM_W'(f_s3) * NUM_W'(mag_s3[a]);
				dv_quo_s[0][a] <= '0;
			end
			dv_pay_s[0].delta   <= dlt_s3;
			dv_pay_s[0].sgn     <= sgn_s3;
			dv_pay_s[0].dy      <= dy_s3;
			dv_pay_s[0].energy  <= energy_s3;
			dv_pay_s[0].contact <= contact_s3;
		end
	end

	// one quotient bit a stage for all three axes
	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		localparam int B = DIV_N - 1 - k;
		logic [NUM_W-1:0] trial;

		assign trial = NUM_W'(dv_pay_s[k].delta) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_pay_s[k+1] <= dv_pay_s[k];
				for (int a = 0; a < AXES; a++) begin
					if (dv_rem_s[k][a] >= trial) begin
						dv_rem_s[k+1][a] <= dv_rem_s[k][a] - trial;
						dv_quo_s[k+1][a] <= dv_quo_s[k][a] | (QUO_W'(1) << B);
					end else begin
						dv_rem_s[k+1][a] <= dv_rem_s[k][a];
						dv_quo_s[k+1][a] <= dv_quo_s[k][a];
					end
				end
			end
		end
	end

	always_comb begin
		ndy    = -(DIFF_W+1)'(dy_s5);
		mom_a  = MOM_W'(frc_s5[0]);
		mom_b  = MOM_W'(ndy);
		mom_sh = mom_s6 >>> FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s5        <= dv_v_s[DIV_N];
			v_s6        <= v_s5;
			out_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// zero separation gives no direction: drop the force
			for (int a = 0; a < AXES; a++) begin
				if (dv_pay_s[DIV_N].delta == '0) begin
					frc_s5[a] <= '0;
				end else if (dv_pay_s[DIV_N].sgn[a]) begin
					frc_s5[a] <= -FRC_W'(dv_quo_s[DIV_N][a]);
				end else begin
					frc_s5[a] <= FRC_W'(dv_quo_s[DIV_N][a]);
				end
			end
			dy_s5      <= dv_pay_s[DIV_N].dy;
			energy_s5  <= dv_pay_s[DIV_N].energy;
			contact_s5 <= dv_pay_s[DIV_N].contact;

			mom_s6     <= mom_a * mom_b;
			frc_s6     <= frc_s5;
			energy_s6  <= energy_s5;
			contact_s6 <= contact_s5;

			force_x_q  <= OUT_W'(frc_s6[0]);
			force_y_q  <= OUT_W'(frc_s6[1]);
			force_z_q  <= OUT_W'(frc_s6[2]);
			moment_q   <= mom_sh[OUT_W-1:0];
			energy_q   <= energy_s6;
			contact_q  <= contact_s6;
		end
	end

	assign out_valid      = out_valid_q;
	assign force_x        = force_x_q;
	assign force_y        = force_y_q;
	assign force_z        = force_z_q;
	assign shear_moment   = moment_q;
	assign overlap_energy = energy_q;
	assign in_contact     = contact_q;

endmodule

// ===== rtl/ssp_checker.sv =====
`include "soft_sphere_pair_force_unit_defines.svh"

module ssp_checker import ssp_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [OUT_W-1:0]  force_x,
	input logic signed [OUT_W-1:0]  force_y,
	input logic signed [OUT_W-1:0]  force_z,
	input logic signed [OUT_W-1:0]  shear_moment,
	input logic [ENERGY_W-1:0]      overlap_energy,
	input logic                     in_contact
);

	logic [4*OUT_W+ENERGY_W:0] out_word;
	logic                      all_zero;
	logic                      force_fits;

	assign out_word   = {force_x, force_y, force_z, shear_moment, overlap_energy, in_contact};
	assign all_zero   = force_x == 0 && force_y == 0 && force_z == 0 &&
		shear_moment == 0 && overlap_energy == 0;
	assign force_fits = (force_x[31:24] == 8'h00 || force_x[31:24] == 8'hFF) &&
		(force_y[31:24] == 8'h00 || force_y[31:24] == 8'hFF) &&
		(force_z[31:24] == 8'h00 || force_z[31:24] == 8'hFF);

	// hold a stalled word
	`SSP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
	`SSP_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_word))

	// a pair out of contact carries nothing
	`SSP_ASSERT_IMP(a_no_contact_zero, out_valid && !in_contact, all_zero)

	// force never exceeds the spring magnitude, which fits in 24 bits
	`SSP_ASSERT_IMP(a_force_range, out_valid, force_fits)

endmodule

bind soft_sphere_pair_force_unit ssp_checker u_ssp_checker (.*);
